>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define FTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property that covers the reset cycles themselves.
`define FTC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/ftc_pkg.sv
// Shared types and constants of the fuzzy tracking controller.
package ftc_pkg;

  localparam int InW    = 16;
  localparam int GradeW = 17;
  localparam int LevelW = 16;
  localparam int MapW   = 30;
  localparam int CfgIdxW = 3;
  localparam int NumRules = 15;
  localparam int SumWW  = 19;
  localparam int SumUW  = 35;
  localparam int NumW   = 36;
  localparam int QW     = 16;
  localparam int DivStages = 8;
  localparam int BitsPerStage = QW / DivStages;

  localparam logic [LevelW-1:0] LevelZeroRst   = 16'd0;
  localparam logic [LevelW-1:0] LevelSmallRst  = 16'd10923;
  localparam logic [LevelW-1:0] LevelMediumRst = 16'd21845;
  localparam logic [LevelW-1:0] LevelLargeRst  = 16'd32768;
  localparam logic [MapW-1:0]   RuleMapRst     = 30'd614967908;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEVEL_ZERO   = 3'd0,
    CFG_LEVEL_SMALL  = 3'd1,
    CFG_LEVEL_MEDIUM = 3'd2,
    CFG_LEVEL_LARGE  = 3'd3,
    CFG_RULE_MAP     = 3'd4
  } cfg_idx_t;

  // Divider working set carried from stage to stage.
  typedef struct packed {
    logic [SumWW-1:0] den;
    logic [SumWW-1:0] rem;
    logic [QW-1:0]    lo;
    logic [QW-1:0]    quo;
    logic             zero;
  } div_t;

endpackage

>>> src/ftc_div_stage.sv
// One stage of the pipelined restoring divider: two quotient bits per stage.
module ftc_div_stage import ftc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_vld,
  input  div_t up_data,
  input  logic dn_adv,
  output logic up_adv,
  output logic vld_r,
  output div_t data_r
);

  div_t data_nxt;
  logic vld_nxt;

  // Shift in the next numerator bit, subtract where the divisor fits.
  always_comb begin
    logic [SumWW:0] trial;
    data_nxt = up_data;
    for (int s = 0; s < BitsPerStage; s++) begin
      trial = {data_nxt.rem, data_nxt.lo[QW-1]};
      data_nxt.lo = {data_nxt.lo[QW-2:0], 1'b0};
      if (trial >= {1'b0, data_nxt.den}) begin
        trial = trial - {1'b0, data_nxt.den};
        data_nxt.quo = {data_nxt.quo[QW-2:0], 1'b1};
      end else begin
        data_nxt.quo = {data_nxt.quo[QW-2:0], 1'b0};
      end
      data_nxt.rem = trial[SumWW-1:0];
    end
  end

  assign up_adv  = !vld_r || dn_adv;
  assign vld_nxt = up_vld;

  // Advance when the next stage can take the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_adv) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> src/fuzzy_tracking_controller_core.sv
// Top level of the fuzzy tracking controller.
// Usage:
//   Input beats on in_* carry a distance error and a velocity, both signed
//   Q2.14. Each input beat gives exactly one output beat on out_*: the
//   weighted-average level in Q1.15 and a flag set when no rule fires (the
//   level is then 0).
//   The pipe has 15 register stages: input register, membership grading,
//   rule weights and products, two adder stages, divider setup, eight
//   divider stages of two bits each, output register.
//   Throughput is one beat per cycle while out_tready stays high; the depth
//   is set by the 16-bit quotient of the divider, taken two bits a stage.
//   Every stage holds a valid bit and advances when the stage after it is
//   empty or moving, so bubbles close up while out_tready is low and
//   in_tready drops only once the whole pipe is full.
//   The levels and the rule map must be written on cfg_* only while the pipe
//   is empty; the block does not enforce this. Unknown indexes are ignored.
//   Reset (rst_n low, synchronous) empties the pipe and restores the
//   default levels and rule map.
module fuzzy_tracking_controller_core import ftc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,   // [15:0] distance_error, [31:16] velocity
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,  // [15:0] control_out
  output logic                out_tuser,  // [0] no_rule_fired
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [MapW-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [LevelW-1:0] lvl0_r, lvl1_r, lvl2_r, lvl3_r;
  logic [MapW-1:0]   map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl0_r <= LevelZeroRst;
      lvl1_r <= LevelSmallRst;
      lvl2_r <= LevelMediumRst;
      lvl3_r <= LevelLargeRst;
      map_r  <= RuleMapRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LEVEL_ZERO:   lvl0_r <= cfg_wdata[LevelW-1:0];
        CFG_LEVEL_SMALL:  lvl1_r <= cfg_wdata[LevelW-1:0];
        CFG_LEVEL_MEDIUM: lvl2_r <= cfg_wdata[LevelW-1:0];
        CFG_LEVEL_LARGE:  lvl3_r <= cfg_wdata[LevelW-1:0];
        CFG_RULE_MAP:     map_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Triangle grade: max(0, 1.0 - slope*|x - centre|).
  function automatic logic [GradeW-1:0] grade(input logic signed [InW-1:0] x,
                                              input logic signed [InW+1:0] c,
                                              input logic [2:0] slope);
    logic signed [InW+1:0] d;
    logic [InW:0]          a;
    logic [InW+3:0]        drop;
    d    = {{2{x[InW-1]}}, x} - c;
    a    = d[InW+1] ? 17'(-d) : 17'(d);
    drop = 20'(a) * 20'(slope);
    grade = (drop >= 20'd32768) ? '0 : 17'(20'd32768 - drop);
  endfunction

  function automatic logic [LevelW-1:0] pick(input logic [1:0] sel,
      input logic [LevelW-1:0] l0, input logic [LevelW-1:0] l1,
      input logic [LevelW-1:0] l2, input logic [LevelW-1:0] l3);
    case (sel)
      2'd0:    pick = l0;
      2'd1:    pick = l1;
      2'd2:    pick = l2;
      default: pick = l3;
    endcase
  endfunction

  // Stage valids and advance chain.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, vo_r;
  logic a1, a2, a3, a4, a5, a6, ao;
  logic [DivStages:0] dv, da;
  div_t               dd [DivStages+1];

  assign ao = !vo_r || out_tready;
  assign da[DivStages] = ao;
  assign a6 = !v6_r || da[0];
  assign a5 = !v5_r || a6;
  assign a4 = !v4_r || a5;
  assign a3 = !v3_r || a4;
  assign a2 = !v2_r || a3;
  assign a1 = !v1_r || a2;
  assign in_tready = a1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0; vo_r <= 1'b0;
    end else begin
      if (a1) v1_r <= in_tvalid;
      if (a2) v2_r <= v1_r;
      if (a3) v3_r <= v2_r;
      if (a4) v4_r <= v3_r;
      if (a5) v5_r <= v4_r;
      if (a6) v6_r <= v5_r;
      if (ao) vo_r <= dv[DivStages];
    end
  end

  // Stage 1: register the input beat.
  logic signed [InW-1:0] dist_r, vel_r;
  always_ff @(posedge clk) begin
    if (a1) begin
      dist_r <= in_tdata[15:0];
      vel_r  <= in_tdata[31:16];
    end
  end

  // Stage 2: grade distance and velocity.
  logic [GradeW-1:0] md_r [5];
  logic [GradeW-1:0] mv_r [3];
  always_ff @(posedge clk) begin
    if (a2) begin
      for (int i = 0; i < 5; i++) begin
        md_r[i] <= grade(dist_r, 18'(8192 * i - 16384), 3'd4);
      end
      for (int j = 0; j < 3; j++) begin
        mv_r[j] <= grade(vel_r, 18'(8192 * j), 3'd5);
      end
    end
  end

  // Stage 3: rule weights and weighted levels.
  logic [GradeW-1:0] w_r [NumRules];
  logic [31:0]       p_r [NumRules];
  for (genvar k = 0; k < NumRules; k++) begin : g_rule
    localparam int I = k / 3;
    localparam int J = k % 3;
    logic [GradeW-1:0] w;
    logic [LevelW-1:0] lv;
    logic [32:0]       prod;
    assign w    = (md_r[I] < mv_r[J]) ? md_r[I] : mv_r[J];
    assign lv   = pick(map_r[2*k +: 2], lvl0_r, lvl1_r, lvl2_r, lvl3_r);
    assign prod = {16'd0, w} * {17'd0, lv};
    always_ff @(posedge clk) begin
      if (a3) begin
        w_r[k] <= w;
        p_r[k] <= prod[31:0];
      end
    end
  end

  // Stage 4: partial sums over groups of five rules.
  logic [17:0] sw3_r [3];
  logic [33:0] su3_r [3];
  always_ff @(posedge clk) begin
    if (a4) begin
      for (int g = 0; g < 3; g++) begin
        sw3_r[g] <= 18'(w_r[5*g]) + 18'(w_r[5*g+1]) + 18'(w_r[5*g+2])
                  + 18'(w_r[5*g+3]) + 18'(w_r[5*g+4]);
        su3_r[g] <= 34'(p_r[5*g]) + 34'(p_r[5*g+1]) + 34'(p_r[5*g+2])
                  + 34'(p_r[5*g+3]) + 34'(p_r[5*g+4]);
      end
    end
  end

  // Stage 5: total weight and total weighted level.
  logic [SumWW-1:0] sw_r;
  logic [SumUW-1:0] su_r;
  always_ff @(posedge clk) begin
    if (a5) begin
      sw_r <= SumWW'(sw3_r[0]) + SumWW'(sw3_r[1]) + SumWW'(sw3_r[2]);
      su_r <= SumUW'(su3_r[0]) + SumUW'(su3_r[1]) + SumUW'(su3_r[2]);
    end
  end

  // Stage 6: add half the divisor for rounding and load the divider.
  logic [NumW-1:0] num;
  div_t            d6_r;
  assign num = NumW'(su_r) + NumW'(sw_r >> 1);
  always_ff @(posedge clk) begin
    if (a6) begin
      d6_r.den  <= sw_r;
      d6_r.rem  <= num[QW +: SumWW];
      d6_r.lo   <= num[QW-1:0];
      d6_r.quo  <= '0;
      d6_r.zero <= (sw_r == '0);
    end
  end

  assign dv[0] = v6_r;
  assign dd[0] = d6_r;

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    ftc_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_vld  (dv[s]),
      .up_data (dd[s]),
      .dn_adv  (da[s+1]),
      .up_adv  (da[s]),
      .vld_r   (dv[s+1]),
      .data_r  (dd[s+1])
    );
  end

  // Output register: force zero when no rule fired.
  logic [QW-1:0] ctl_r;
  logic          none_r;
  always_ff @(posedge clk) begin
    if (ao) begin
      ctl_r  <= dd[DivStages].zero ? '0 : dd[DivStages].quo;
      none_r <= dd[DivStages].zero;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = ctl_r;
  assign out_tuser  = none_r;

endmodule

>>> src/ftc_checker.sv
// Port-level checker for the fuzzy tracking controller, bound to the top level.
`include "assert_macros.svh"
module ftc_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  `FTC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "output beat dropped")
  `FTC_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled data moved")
  `FTC_ASSERT(a_none_zero, out_tvalid && out_tuser |-> out_tdata == 16'd0, "no-rule level not zero")
  `FTC_ASSERT(a_empty_ready, !out_tvalid |-> in_tready, "input blocked while output empty")
  `FTC_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind fuzzy_tracking_controller_core ftc_port_props u_ftc_checker (.*);
